FILE: src/particle_euler_update_table_core_macros.svh
// ----------------------------------------------------------------------------
// particle_euler_update_table_core_macros
// assertion helpers for the particle table
// ----------------------------------------------------------------------------
`ifndef PARTICLE_EULER_UPDATE_TABLE_CORE_MACROS_SVH
`define PARTICLE_EULER_UPDATE_TABLE_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define PEUT_ASSERT_ALWAYS(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("peut check failed");

// antecedent implies consequent in the same cycle
`define PEUT_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("peut check failed");

`endif

FILE: src/peut_pkg.sv
// ----------------------------------------------------------------------------
// peut_pkg
// types, codes and saturation helpers shared by the particle table
// ----------------------------------------------------------------------------
package peut_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [1:0] CFG_GRAVITY = 2'd0;
  localparam logic [1:0] CFG_LIMIT   = 2'd1;

  localparam logic [15:0] GRAVITY_RESET = 16'd24576;
  localparam logic [9:0]  LIMIT_RESET   = 10'd500;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_TICK,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_TSTART,
    S_TMUL,
    S_TUPD,
    S_TMOVE,
    S_TFIN
  } back_state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic [15:0]        life_left;
    logic [15:0]        particle_size;
    logic [15:0]        time_step;
    logic [8:0]         entry_index;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         live_count;
    logic               accepted;
    logic [9:0]         removed_count;
    logic               read_valid;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic [15:0]        out_life;
    logic [15:0]        out_size;
  } out_item_t;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic [15:0]        life;
    logic [15:0]        size;
  } entry_t;

  typedef struct packed {
    op_t      op;
    in_item_t data;
  } cmd_item_t;

  typedef struct packed {
    logic      valid;
    cmd_item_t item;
  } queue_head_t;

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v[24] != v[23]) begin
      r = v[24] ? 24'sh800000 : 24'sh7fffff;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v[17:15] != {3{v[17]}}) begin
      r = v[17] ? 16'sh8000 : 16'sh7fff;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: src/peut_front.sv
// ----------------------------------------------------------------------------
// peut_front
// accepts items, decodes the command and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module peut_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  peut_pkg::in_item_t in_data,
  output peut_pkg::queue_head_t q_head,
  input  logic               q_pop
);
  import peut_pkg::*;

  cmd_item_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  op_t        op_dec;

  always_comb begin
    unique case (in_data.command)
      CMD_INSERT: op_dec = OP_INSERT;
      CMD_TICK:   op_dec = OP_TICK;
      CMD_CLEAR:  op_dec = OP_CLEAR;
      default:    op_dec = OP_READ;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op_dec, data: in_data};
    end
  end

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.item  = q_r[rd_ptr_r];

endmodule

FILE: src/peut_back.sv
// ----------------------------------------------------------------------------
// peut_back
// executes queued commands against the particle memory, one entry at a time
// ----------------------------------------------------------------------------
`include "particle_euler_update_table_core_macros.svh"

module peut_back #(
  parameter int CAPACITY = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  peut_pkg::queue_head_t q_head,
  output logic                  q_pop,
  input  logic [15:0]           gravity,
  input  logic [9:0]            particle_limit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output peut_pkg::out_item_t   out_data
);
  import peut_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = (CW > 10) ? CW : 10;

  entry_t mem [CAPACITY];

  back_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] removed_r, removed_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;
  logic          out_load;
  logic          out_free;

  logic [15:0]   dt_r, dt_nxt;
  logic [15:0]   dv_r, dv_nxt;
  logic signed [32:0] prod_x_r, prod_y_r, prod_z_r;
  logic signed [32:0] prod_x_nxt, prod_y_nxt, prod_z_nxt;
  entry_t        rd_data_r;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  logic [LW-1:0] cnt_ext, lim_ext, ridx_ext, rem_ext, cnt_nxt_ext;
  logic [31:0]   grav_prod;
  logic signed [16:0] dt_s;
  logic signed [24:0] sum_x, sum_y, sum_z;
  logic signed [17:0] vy_diff;
  logic signed [16:0] life_diff;
  entry_t        upd;
  logic          kill;
  cmd_item_t     head;

  assign head     = q_head.item;
  assign out_free = !out_valid_r || !out_stall;

  assign cnt_ext  = LW'(count_r);
  assign lim_ext  = (LW'(particle_limit) < LW'(CAPACITY)) ? LW'(particle_limit) : LW'(CAPACITY);
  assign ridx_ext = LW'(head.data.entry_index);
  assign cnt_nxt_ext = LW'(count_nxt);
  assign rem_ext  = LW'(removed_nxt);

  // tick arithmetic
  assign dt_s       = $signed({1'b0, dt_r});
  assign grav_prod  = 32'(gravity) * 32'(dt_r);
  assign prod_x_nxt = 33'(rd_data_r.vx) * 33'(dt_s);
  assign prod_y_nxt = 33'(rd_data_r.vy) * 33'(dt_s);
  assign prod_z_nxt = 33'(rd_data_r.vz) * 33'(dt_s);
  assign sum_x      = 25'(rd_data_r.px) + 25'($signed(prod_x_r[32:16]));
  assign sum_y      = 25'(rd_data_r.py) + 25'($signed(prod_y_r[32:16]));
  assign sum_z      = 25'(rd_data_r.pz) + 25'($signed(prod_z_r[32:16]));
  assign vy_diff    = 18'(rd_data_r.vy) - $signed({2'b00, dv_r});
  assign life_diff  = $signed({1'b0, rd_data_r.life}) - dt_s;

  always_comb begin
    upd      = rd_data_r;
    upd.px   = sat24(sum_x);
    upd.py   = sat24(sum_y);
    upd.pz   = sat24(sum_z);
    upd.vy   = sat16(vy_diff);
    upd.life = life_diff[15:0];
    kill     = life_diff[16] || (life_diff == 17'sd0) || upd.py[23];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_head.valid && out_free) begin
          if (head.op == OP_TICK) begin
            state_nxt = S_TSTART;
          end else if (head.op == OP_READ && ridx_ext < cnt_ext) begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ:   if (out_free) state_nxt = S_IDLE;
      S_TSTART: state_nxt = (count_r == '0) ? S_TFIN : S_TMUL;
      S_TMUL:   state_nxt = S_TUPD;
      S_TUPD: begin
        if (kill) begin
          state_nxt = S_TMOVE;
        end else begin
          state_nxt = (idx_r == '0) ? S_TFIN : S_TMUL;
        end
      end
      S_TMOVE:  state_nxt = (idx_r == '0) ? S_TFIN : S_TMUL;
      S_TFIN:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop       = 1'b0;
    count_nxt   = count_r;
    removed_nxt = removed_r;
    idx_nxt     = idx_r;
    dt_nxt      = dt_r;
    dv_nxt      = dv_r;
    rd_en       = 1'b0;
    rd_addr     = idx_r;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_data     = upd;
    out_load    = 1'b0;
    out_nxt     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (q_head.valid && out_free) begin
          q_pop = 1'b1;
          unique case (head.op)
            OP_INSERT: begin
              out_load = 1'b1;
              if (cnt_ext < lim_ext) begin
                wr_en      = 1'b1;
                wr_addr    = count_r[AW-1:0];
                wr_data    = '{px: head.data.pos_x, py: head.data.pos_y,
                               pz: head.data.pos_z, vx: head.data.vel_x,
                               vy: head.data.vel_y, vz: head.data.vel_z,
                               life: head.data.life_left,
                               size: head.data.particle_size};
                count_nxt  = count_r + 1'b1;
                out_nxt.accepted = 1'b1;
              end
            end
            OP_TICK: begin
              dt_nxt      = head.data.time_step;
              removed_nxt = '0;
            end
            OP_CLEAR: begin
              out_load  = 1'b1;
              count_nxt = '0;
            end
            default: begin
              if (ridx_ext < cnt_ext) begin
                rd_en   = 1'b1;
                rd_addr = ridx_ext[AW-1:0];
              end else begin
                out_load = 1'b1;
              end
            end
          endcase
          out_nxt.live_count = cnt_nxt_ext[9:0];
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_nxt.live_count = cnt_ext[9:0];
          out_nxt.read_valid = 1'b1;
          out_nxt.out_x      = rd_data_r.px;
          out_nxt.out_y      = rd_data_r.py;
          out_nxt.out_z      = rd_data_r.pz;
          out_nxt.out_life   = rd_data_r.life;
          out_nxt.out_size   = rd_data_r.size;
        end
      end
      S_TSTART: begin
        dv_nxt = grav_prod[31:16];
        if (count_r != '0) begin
          idx_nxt = AW'(count_r - 1'b1);
          rd_en   = 1'b1;
          rd_addr = AW'(count_r - 1'b1);
        end
      end
      S_TMUL: begin
      end
      S_TUPD: begin
        if (kill) begin
          // fetch the current last entry to fill the hole
          rd_en   = 1'b1;
          rd_addr = AW'(count_r - 1'b1);
        end else begin
          wr_en = 1'b1;
          if (idx_r != '0) begin
            idx_nxt = idx_r - 1'b1;
            rd_en   = 1'b1;
            rd_addr = idx_r - 1'b1;
          end
        end
      end
      S_TMOVE: begin
        wr_en       = 1'b1;
        wr_data     = rd_data_r;
        count_nxt   = count_r - 1'b1;
        removed_nxt = removed_r + 1'b1;
        if (idx_r != '0) begin
          idx_nxt = idx_r - 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_r - 1'b1;
        end
      end
      S_TFIN: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_nxt.live_count    = cnt_ext[9:0];
          out_nxt.removed_count = rem_ext[9:0];
        end
      end
      default: begin
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    removed_r <= removed_nxt;
    idx_r     <= idx_nxt;
    dt_r      <= dt_nxt;
    dv_r      <= dv_nxt;
    prod_x_r  <= prod_x_nxt;
    prod_y_r  <= prod_y_nxt;
    prod_z_r  <= prod_z_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  // particle memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PEUT_ASSERT_ALWAYS(a_count_in_range, clk, rst_n, LW'(count_r) <= LW'(CAPACITY))
  `PEUT_ASSERT_IMPLY(a_move_has_entry, clk, rst_n, state_r == S_TMOVE, count_r != '0)
  `PEUT_ASSERT_IMPLY(a_walk_in_table, clk, rst_n,
    state_r == S_TMUL || state_r == S_TUPD, LW'(idx_r) < LW'(count_r))
  `PEUT_ASSERT_IMPLY(a_no_result_overrun, clk, rst_n,
    out_valid_r && out_stall, !out_load)

endmodule

FILE: src/particle_euler_update_table_core.sv
// ----------------------------------------------------------------------------
// particle_euler_update_table_core
// particle table with fixed-point euler update, insert, clear and read
// ----------------------------------------------------------------------------
// usage:
//   in_valid / in_stall / in_data carry one command item; it is taken at an
//   edge with in_valid high and in_stall low. a two-item queue sits in front
//   of the executing part, so the sender is only stalled when it is full.
//   out_valid / out_stall / out_data return exactly one result per item, in
//   order; a stalled result holds and the queue keeps filling behind it.
//   cfg_valid / cfg_ready / cfg_index / cfg_data write gravity (0) or the
//   particle limit (1); cfg_ready is always high.
//   insert and clear finish in the idle state, so they stream at one item a
//   cycle while no result is stalled; read adds S_READ for the registered
//   memory access. tick runs S_TSTART, then S_TMUL and S_TUPD per live entry,
//   S_TMOVE per removed entry, then S_TFIN, for read, multiply and write-back.
//   reset empties the table and restores the register defaults; memory
//   contents are not cleared, entries are only read below the live count.
// ----------------------------------------------------------------------------
module particle_euler_update_table_core #(
  parameter int CAPACITY = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  peut_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output peut_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import peut_pkg::*;

  logic [15:0] gravity_r, gravity_nxt;
  logic [9:0]  limit_r, limit_nxt;
  queue_head_t q_head;
  logic        q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    gravity_nxt = gravity_r;
    limit_nxt   = limit_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRAVITY: gravity_nxt = cfg_data;
        CFG_LIMIT:   limit_nxt   = cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= GRAVITY_RESET;
      limit_r   <= LIMIT_RESET;
    end else begin
      gravity_r <= gravity_nxt;
      limit_r   <= limit_nxt;
    end
  end

  peut_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  peut_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .gravity        (gravity_r),
    .particle_limit (limit_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule
